[design/kcl_pkg.sv]
`default_nettype none
package kcl_pkg;

   // Length of the secret code; the entry ring always holds eight slots.
   localparam int CODE_LEN    = 8;
   localparam int ENTRY_SLOTS = 8;
   localparam int PTR_W       = 3;

   // Event codes carried in the func field.
   localparam logic [1:0] FUNC_KEY  = 2'd0;
   localparam logic [1:0] FUNC_TONE = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // Key codes.
   localparam logic [3:0] KEY_CLEAR   = 4'd10;
   localparam logic [3:0] KEY_CONFIRM = 4'd11;
   localparam logic [3:0] KEY_BELL    = 4'd15;
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

   // Sound modes.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_BELL  = 2'd1;
   localparam logic [1:0] MODE_ALARM = 2'd2;

   // Confirm verdicts.
   localparam logic [1:0] VERDICT_NONE     = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
   localparam logic [1:0] VERDICT_REJECTED = 2'd2;

   // Tone timer reload choices.
   localparam logic [1:0] RELOAD_SHORT = 2'd0;
   localparam logic [1:0] RELOAD_LONG  = 2'd1;
   localparam logic [1:0] RELOAD_FREE  = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_DIGITS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRONG_LIMIT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_PHASE_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SECOND = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_SECONDS     = 3'd4;

   typedef struct packed {
      logic [31:0] code_digits;
      logic [3:0]  wrong_limit;
      logic [9:0]  tone_phase_count;
      logic [5:0]  ticks_per_second;
      logic [3:0]  open_seconds;
   } kcl_cfg_type;

   typedef struct packed {
      logic             relay_on;
      logic             alarm_level;
      logic             bell_level;
      logic             tone_running;
      logic [1:0]       tone_reload;
      logic [1:0]       mode;
      logic [1:0]       verdict;
      logic [PTR_W-1:0] entry_position;
      logic [3:0]       wrong_attempts;
   } kcl_result_type;

endpackage
`default_nettype wire

[design/kcl_csr.sv]
`default_nettype none
module kcl_csr
   import kcl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   write_en,
   input  wire logic [CSR_INDEX_W-1:0] write_index,
   input  wire logic [31:0]            write_data,
   output kcl_cfg_type                 cfg
);

   kcl_cfg_type cfg_ff;
   kcl_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (write_index)
            CSR_CODE_DIGITS:      cfg_in.code_digits      = write_data;
            CSR_WRONG_LIMIT:      cfg_in.wrong_limit      = write_data[3:0];
            CSR_TONE_PHASE_COUNT: cfg_in.tone_phase_count = write_data[9:0];
            CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = write_data[5:0];
            CSR_OPEN_SECONDS:     cfg_in.open_seconds     = write_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_digits      <= 32'd1144201745;
         cfg_ff.wrong_limit      <= 4'd3;
         cfg_ff.tone_phase_count <= 10'd400;
         cfg_ff.ticks_per_second <= 6'd20;
         cfg_ff.open_seconds     <= 4'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[design/kcl_engine.sv]
`default_nettype none
module kcl_engine
   import kcl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [1:0] func,
   input  wire logic [3:0] key_code,
   input  kcl_cfg_type     cfg,
   output kcl_result_type  result
);

   logic [3:0]       entry_ff [ENTRY_SLOTS];
   logic [3:0]       entry_in [ENTRY_SLOTS];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             fail_ff, fail_in;
   logic [3:0]       attempts_ff, attempts_in;
   logic [1:0]       mode_ff, mode_in;
   logic             tone_en_ff, tone_en_in;
   logic [10:0]      tone_cnt_ff, tone_cnt_in;
   logic [1:0]       reload_ff, reload_in;
   logic             bell_ff, bell_in;
   logic             alarm_ff, alarm_in;
   logic             relay_ff, relay_in;
   logic             door_on_ff, door_on_in;
   logic [5:0]       subsec_ff, subsec_in;
   logic [3:0]       sec_ff, sec_in;
   logic [1:0]       verdict_ff, verdict_in;

   logic             mismatch;
   logic [PTR_W:0]   ptr_inc;
   logic [10:0]      tone_inc;
   logic [10:0]      phase_ext;
   logic [10:0]      phase_twice;
   logic [3:0]       attempts_inc;

   // Parallel compare of the typed digits against the stored code.
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < CODE_LEN; i++) begin
         if (cfg.code_digits[4*i +: 4] != entry_ff[i]) begin
            mismatch = 1'b1;
         end
      end
   end

   assign ptr_inc      = {1'b0, ptr_ff} + 1'b1;
   assign tone_inc     = tone_cnt_ff + 11'd1;
   assign phase_ext    = {1'b0, cfg.tone_phase_count};
   assign phase_twice  = {cfg.tone_phase_count, 1'b0};
   assign attempts_inc = attempts_ff + 4'd1;

   always_comb begin
      entry_in    = entry_ff;
      ptr_in      = ptr_ff;
      fail_in     = fail_ff;
      attempts_in = attempts_ff;
      mode_in     = mode_ff;
      tone_en_in  = tone_en_ff;
      tone_cnt_in = tone_cnt_ff;
      reload_in   = reload_ff;
      bell_in     = bell_ff;
      alarm_in    = alarm_ff;
      relay_in    = relay_ff;
      door_on_in  = door_on_ff;
      subsec_in   = subsec_ff;
      sec_in      = sec_ff;
      verdict_in  = verdict_ff;

      unique case (func)
         FUNC_KEY: begin
            if (key_code <= KEY_DIGIT_MAX) begin
               entry_in[ptr_ff] = key_code;
               if (ptr_inc >= (PTR_W+1)'(CODE_LEN)) begin
                  ptr_in = '0;
               end else begin
                  ptr_in = ptr_inc[PTR_W-1:0];
               end
            end else if (key_code == KEY_CLEAR) begin
               for (int i = 0; i < ENTRY_SLOTS; i++) begin
                  entry_in[i] = '0;
               end
               ptr_in     = '0;
               fail_in    = 1'b0;
               verdict_in = VERDICT_NONE;
            end else if (key_code == KEY_CONFIRM) begin
               // The fail mark is sticky: once set, every confirm is rejected until the entry is cleared.
               fail_in = fail_ff | mismatch;
               if (!(fail_ff | mismatch)) begin
                  verdict_in = VERDICT_ACCEPTED;
                  relay_in   = 1'b1;
                  door_on_in = 1'b1;
                  mode_in    = MODE_IDLE;
                  alarm_in   = 1'b0;
                  tone_en_in = 1'b0;
               end else begin
                  verdict_in  = VERDICT_REJECTED;
                  attempts_in = attempts_inc;
                  if (attempts_inc == cfg.wrong_limit) begin
                     tone_en_in  = 1'b1;
                     mode_in     = MODE_ALARM;
                     attempts_in = '0;
                  end
               end
            end else if (key_code == KEY_BELL) begin
               tone_en_in = 1'b1;
               mode_in    = MODE_BELL;
            end
         end
         FUNC_TONE: begin
            if (tone_en_ff && mode_ff == MODE_BELL) begin
               bell_in     = ~bell_ff;
               tone_cnt_in = tone_inc;
               if (tone_inc < phase_ext) begin
                  reload_in = RELOAD_SHORT;
               end else if (tone_inc < phase_twice) begin
                  reload_in = RELOAD_LONG;
               end else begin
                  tone_cnt_in = '0;
                  tone_en_in  = 1'b0;
                  mode_in     = MODE_IDLE;
               end
            end else if (tone_en_ff && mode_ff == MODE_ALARM) begin
               alarm_in    = ~alarm_ff;
               tone_cnt_in = tone_inc;
               if (tone_inc < phase_ext) begin
                  reload_in = RELOAD_SHORT;
               end else begin
                  tone_cnt_in = '0;
                  reload_in   = RELOAD_FREE;
               end
            end
         end
         FUNC_TICK: begin
            if (door_on_ff) begin
               subsec_in = subsec_ff + 6'd1;
               if (subsec_in == cfg.ticks_per_second) begin
                  sec_in    = sec_ff + 4'd1;
                  subsec_in = '0;
               end
            end
         end
         default: ;
      endcase

      // Door closing is checked after every event while the timer runs.
      if (door_on_in && sec_in == cfg.open_seconds) begin
         relay_in   = 1'b0;
         sec_in     = '0;
         door_on_in = 1'b0;
         for (int i = 0; i < ENTRY_SLOTS; i++) begin
            entry_in[i] = '0;
         end
         ptr_in     = '0;
         fail_in    = 1'b0;
         verdict_in = VERDICT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRY_SLOTS; i++) begin
            entry_ff[i] <= '0;
         end
         ptr_ff      <= '0;
         fail_ff     <= 1'b0;
         attempts_ff <= '0;
         mode_ff     <= MODE_IDLE;
         tone_en_ff  <= 1'b0;
         tone_cnt_ff <= '0;
         reload_ff   <= RELOAD_SHORT;
         bell_ff     <= 1'b0;
         alarm_ff    <= 1'b0;
         relay_ff    <= 1'b0;
         door_on_ff  <= 1'b0;
         subsec_ff   <= '0;
         sec_ff      <= '0;
         verdict_ff  <= VERDICT_NONE;
      end else if (advance) begin
         entry_ff    <= entry_in;
         ptr_ff      <= ptr_in;
         fail_ff     <= fail_in;
         attempts_ff <= attempts_in;
         mode_ff     <= mode_in;
         tone_en_ff  <= tone_en_in;
         tone_cnt_ff <= tone_cnt_in;
         reload_ff   <= reload_in;
         bell_ff     <= bell_in;
         alarm_ff    <= alarm_in;
         relay_ff    <= relay_in;
         door_on_ff  <= door_on_in;
         subsec_ff   <= subsec_in;
         sec_ff      <= sec_in;
         verdict_ff  <= verdict_in;
      end
   end

   // The word reports the state as it stands after the event.
   always_comb begin
      result.relay_on       = relay_in;
      result.alarm_level    = alarm_in;
      result.bell_level     = bell_in;
      result.tone_running   = tone_en_in;
      result.tone_reload    = reload_in;
      result.mode           = mode_in;
      result.verdict        = verdict_in;
      result.entry_position = ptr_in;
      result.wrong_attempts = attempts_in;
   end

endmodule
`default_nettype wire

[design/keypad_code_lock_controller_core.sv]
`default_nettype none
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_func, req_key_code
// rsp       out        rsp_valid/rsp_ready   relay, tone, mode, verdict and count fields
// csr       in         csr_valid/csr_ready   csr_index, csr_data
//
// One word in, one word out. A word waits in the input register, and its result is
// written to the output register when the word advances out of it.
// A new word is taken every cycle while the output does not stall.
// A stalled output holds the input register; req_ready then drops.
// Synchronous reset clears the lock state and the valid flags and reloads the register
// defaults; csr_ready is always high.
module keypad_code_lock_controller_core
   import kcl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [1:0]             req_func,
   input  wire logic [3:0]             req_key_code,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_relay_on,
   output      logic                   rsp_alarm_level,
   output      logic                   rsp_bell_level,
   output      logic                   rsp_tone_running,
   output      logic [1:0]             rsp_tone_reload,
   output      logic [1:0]             rsp_mode,
   output      logic [1:0]             rsp_verdict,
   output      logic [PTR_W-1:0]       rsp_entry_position,
   output      logic [3:0]             rsp_wrong_attempts,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);

   kcl_cfg_type    cfg;
   kcl_result_type step_result;
   kcl_result_type rsp_ff;

   logic       in_valid_ff;
   logic [1:0] in_func_ff;
   logic [3:0] in_key_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign csr_ready = 1'b1;

   kcl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid),
      .write_index (csr_index),
      .write_data  (csr_data),
      .cfg         (cfg)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_func_ff <= req_func;
         in_key_ff  <= req_key_code;
      end
   end

   kcl_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .func     (in_func_ff),
      .key_code (in_key_ff),
      .cfg      (cfg),
      .result   (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_relay_on       = rsp_ff.relay_on;
   assign rsp_alarm_level    = rsp_ff.alarm_level;
   assign rsp_bell_level     = rsp_ff.bell_level;
   assign rsp_tone_running   = rsp_ff.tone_running;
   assign rsp_tone_reload    = rsp_ff.tone_reload;
   assign rsp_mode           = rsp_ff.mode;
   assign rsp_verdict        = rsp_ff.verdict;
   assign rsp_entry_position = rsp_ff.entry_position;
   assign rsp_wrong_attempts = rsp_ff.wrong_attempts;

   // The tone timer runs exactly when a bell or alarm is sounding.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tone_running == (rsp_mode != MODE_IDLE)))
      else $error("tone enable disagrees with sound mode");

   // The entry pointer never leaves the code length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_position < PTR_W'(CODE_LEN) || CODE_LEN == ENTRY_SLOTS))
      else $error("entry pointer beyond code length");

   // A word held in the input register must not be lost while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid && !rsp_ready) |=> in_valid_ff)
      else $error("input word dropped during output stall");

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
`default_nettype wire

[dv/tb_keypad_code_lock_controller_core.sv]
`default_nettype none
module tb_keypad_code_lock_controller_core;
   import kcl_pkg::*;

   localparam logic [1:0] FUNC_NONE   = 2'd3;
   localparam int         PHASES      = 7;
   localparam int         PHASE_WORDS = 105;
   localparam int         LONG_HOLD   = 400;
   localparam int         QUIET_LIMIT = 3000;
   localparam int         MAX_TICK_RUN = 120;

   // Register values after reset.
   localparam logic [31:0] RESET_CODE        = 32'd1144201745;
   localparam logic [3:0]  RESET_WRONG_LIMIT = 4'd3;
   localparam logic [9:0]  RESET_PHASE_COUNT = 10'd400;
   localparam logic [5:0]  RESET_TICKS       = 6'd20;
   localparam logic [3:0]  RESET_OPEN        = 4'd4;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] key;
   } keypad_event_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_func = '0;
   logic [3:0]             req_key_code = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_relay_on;
   logic                   rsp_alarm_level;
   logic                   rsp_bell_level;
   logic                   rsp_tone_running;
   logic [1:0]             rsp_tone_reload;
   logic [1:0]             rsp_mode;
   logic [1:0]             rsp_verdict;
   logic [PTR_W-1:0]       rsp_entry_position;
   logic [3:0]             rsp_wrong_attempts;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_data = '0;

   keypad_code_lock_controller_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_relay_on       (rsp_relay_on),
      .rsp_alarm_level    (rsp_alarm_level),
      .rsp_bell_level     (rsp_bell_level),
      .rsp_tone_running   (rsp_tone_running),
      .rsp_tone_reload    (rsp_tone_reload),
      .rsp_mode           (rsp_mode),
      .rsp_verdict        (rsp_verdict),
      .rsp_entry_position (rsp_entry_position),
      .rsp_wrong_attempts (rsp_wrong_attempts),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow of the lock as the block should see it.
   kcl_cfg_type      lock_cfg;
   logic [3:0]       entry_digits [ENTRY_SLOTS];
   logic [PTR_W-1:0] entry_ptr;
   logic             mismatch_seen;
   logic [3:0]       rejections;
   logic [1:0]       sound;
   logic             tone_on;
   logic [10:0]      tone_ticks;
   logic [1:0]       reload_sel;
   logic             bell_q;
   logic             alarm_q;
   logic             relay_q;
   logic             door_running;
   logic [5:0]       sub_ticks;
   logic [3:0]       seconds;
   logic [1:0]       verdict_q;

   keypad_event_type key_events [$];
   kcl_result_type   due_outputs [$];
   kcl_cfg_type      plan_cfg;
   int             events_queued = 0;
   int             events_accepted = 0;
   int             error_count = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             holds_asked = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             stall_style = 0;
   int             style_left = 0;
   int             pattern_count = 0;
   int             quiet_cycles = 0;

   function automatic void clear_lock_entry();
      int i;
      for (i = 0; i < ENTRY_SLOTS; i++) entry_digits[i] = '0;
      entry_ptr = '0;
      mismatch_seen = 1'b0;
      verdict_q = VERDICT_NONE;
   endfunction

   function automatic void reset_lock_model();
      lock_cfg.code_digits = RESET_CODE;
      lock_cfg.wrong_limit = RESET_WRONG_LIMIT;
      lock_cfg.tone_phase_count = RESET_PHASE_COUNT;
      lock_cfg.ticks_per_second = RESET_TICKS;
      lock_cfg.open_seconds = RESET_OPEN;
      clear_lock_entry();
      rejections = '0;
      sound = MODE_IDLE;
      tone_on = 1'b0;
      tone_ticks = '0;
      reload_sel = RELOAD_SHORT;
      bell_q = 1'b0;
      alarm_q = 1'b0;
      relay_q = 1'b0;
      door_running = 1'b0;
      sub_ticks = '0;
      seconds = '0;
   endfunction

   function automatic kcl_result_type predict_lock_outputs(input logic [1:0] f,
                                                           input logic [3:0] k);
      int             i;
      int             next_ptr;
      kcl_result_type r;
      case (f)
         FUNC_KEY: begin
            if (k <= KEY_DIGIT_MAX) begin
               entry_digits[entry_ptr] = k;
               next_ptr = int'(entry_ptr) + 1;
               if (next_ptr >= CODE_LEN) next_ptr = 0;
               entry_ptr = PTR_W'(next_ptr);
            end else if (k == KEY_CLEAR) begin
               clear_lock_entry();
            end else if (k == KEY_CONFIRM) begin
               // The fail mark is sticky: an earlier mismatch rejects every later confirm until a clear.
               for (i = 0; i < CODE_LEN; i++)
                  if (lock_cfg.code_digits[4*i +: 4] != entry_digits[i]) mismatch_seen = 1'b1;
               if (!mismatch_seen) begin
                  verdict_q = VERDICT_ACCEPTED;
                  relay_q = 1'b1;
                  door_running = 1'b1;
                  sound = MODE_IDLE;
                  alarm_q = 1'b0;
                  tone_on = 1'b0;
               end else begin
                  verdict_q = VERDICT_REJECTED;
                  rejections = rejections + 4'd1;
                  if (rejections == lock_cfg.wrong_limit) begin
                     tone_on = 1'b1;
                     sound = MODE_ALARM;
                     rejections = '0;
                  end
               end
            end else if (k == KEY_BELL) begin
               tone_on = 1'b1;
               sound = MODE_BELL;
            end
         end
         FUNC_TONE: begin
            if (tone_on && sound == MODE_BELL) begin
               bell_q = ~bell_q;
               tone_ticks = tone_ticks + 11'd1;
               if (tone_ticks < lock_cfg.tone_phase_count) begin
                  reload_sel = RELOAD_SHORT;
               end else if (tone_ticks < {lock_cfg.tone_phase_count, 1'b0}) begin
                  reload_sel = RELOAD_LONG;
               end else begin
                  tone_ticks = '0;
                  tone_on = 1'b0;
                  sound = MODE_IDLE;
               end
            end else if (tone_on && sound == MODE_ALARM) begin
               alarm_q = ~alarm_q;
               tone_ticks = tone_ticks + 11'd1;
               if (tone_ticks < lock_cfg.tone_phase_count) begin
                  reload_sel = RELOAD_SHORT;
               end else begin
                  tone_ticks = '0;
                  reload_sel = RELOAD_FREE;
               end
            end
         end
         FUNC_TICK: begin
            if (door_running) begin
               sub_ticks = sub_ticks + 6'd1;
               if (sub_ticks == lock_cfg.ticks_per_second) begin
                  seconds = seconds + 4'd1;
                  sub_ticks = '0;
               end
            end
         end
         default: ;
      endcase
      // The door closes at the end of any word once the second count reaches the limit.
      if (door_running && seconds == lock_cfg.open_seconds) begin
         relay_q = 1'b0;
         seconds = '0;
         clear_lock_entry();
         door_running = 1'b0;
      end
      r.relay_on = relay_q;
      r.alarm_level = alarm_q;
      r.bell_level = bell_q;
      r.tone_running = tone_on;
      r.tone_reload = reload_sel;
      r.mode = sound;
      r.verdict = verdict_q;
      r.entry_position = entry_ptr;
      r.wrong_attempts = rejections;
      return r;
   endfunction

   // Driver: offers words in bursts and keeps the lock shadow in step with what is taken.
   always @(posedge clock) begin
      logic             offer;
      keypad_event_type ev;
      offer = 1'b0;
      ev = '0;
      if (reset) begin
         reset_lock_model();
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CODE_DIGITS:      lock_cfg.code_digits = csr_data;
               CSR_WRONG_LIMIT:      lock_cfg.wrong_limit = csr_data[3:0];
               CSR_TONE_PHASE_COUNT: lock_cfg.tone_phase_count = csr_data[9:0];
               CSR_TICKS_PER_SECOND: lock_cfg.ticks_per_second = csr_data[5:0];
               CSR_OPEN_SECONDS:     lock_cfg.open_seconds = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            due_outputs.push_back(predict_lock_outputs(req_func, req_key_code));
            events_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (key_events.size() > 0) begin
               ev = key_events.pop_front();
               offer = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 3))
                     0, 1: gap_left = 0;
                     2: gap_left = $urandom_range(1, 2);
                     default: gap_left = $urandom_range(3, 8);
                  endcase
               end
            end
            req_valid <= offer;
            if (offer) begin
               req_func <= ev.func;
               req_key_code <= ev.key;
            end
         end
      end
   end

   // Receiver: changes its stall pattern now and then, and serves long hold-offs on request.
   always @(posedge clock) begin
      logic take;
      take = 1'b1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
            take = 1'b0;
         end else begin
            if (style_left == 0) begin
               stall_style = $urandom_range(0, 3);
               style_left = $urandom_range(20, 200);
            end else begin
               style_left--;
            end
            pattern_count++;
            case (stall_style)
               0: take = 1'b1;
               1: take = ($urandom_range(0, 9) < 7);
               2: take = ((pattern_count % 4) != 3);
               default: take = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= take;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Monitor: every result word is checked against the oldest prediction.
   always @(posedge clock) begin
      kcl_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_outputs.size() == 0) begin
            $display("%0t: result word with no prediction waiting", $time);
            error_count++;
         end else begin
            want = due_outputs.pop_front();
            check_field("relay_on", 32'(want.relay_on), 32'(rsp_relay_on));
            check_field("alarm_level", 32'(want.alarm_level), 32'(rsp_alarm_level));
            check_field("bell_level", 32'(want.bell_level), 32'(rsp_bell_level));
            check_field("tone_running", 32'(want.tone_running), 32'(rsp_tone_running));
            check_field("tone_reload", 32'(want.tone_reload), 32'(rsp_tone_reload));
            check_field("mode", 32'(want.mode), 32'(rsp_mode));
            check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
            check_field("entry_position", 32'(want.entry_position),
                        32'(rsp_entry_position));
            check_field("wrong_attempts", 32'(want.wrong_attempts),
                        32'(rsp_wrong_attempts));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_event(input logic [1:0] f, input logic [3:0] k);
      keypad_event_type ev;
      ev.func = f;
      ev.key = k;
      key_events.push_back(ev);
      events_queued++;
   endtask

   task automatic add_repeated(input logic [1:0] f, input int count);
      int i;
      for (i = 0; i < count; i++) add_event(f, 4'($urandom_range(0, 15)));
   endtask

   // Clear, the stored digits (a random digit where a nibble cannot be typed), confirm.
   task automatic type_code();
      int         i;
      logic [3:0] nib;
      add_event(FUNC_KEY, KEY_CLEAR);
      for (i = 0; i < CODE_LEN; i++) begin
         nib = plan_cfg.code_digits[4*i +: 4];
         add_event(FUNC_KEY, (nib > KEY_DIGIT_MAX) ? 4'($urandom_range(0, 9)) : nib);
      end
      add_event(FUNC_KEY, KEY_CONFIRM);
   endtask

   task automatic load_registers(input kcl_cfg_type c);
      logic [31:0]            values [5];
      logic [CSR_INDEX_W-1:0] indexes [5];
      int                     i;
      values[0] = c.code_digits;
      values[1] = 32'(c.wrong_limit);
      values[2] = 32'(c.tone_phase_count);
      values[3] = 32'(c.ticks_per_second);
      values[4] = 32'(c.open_seconds);
      indexes[0] = CSR_CODE_DIGITS;
      indexes[1] = CSR_WRONG_LIMIT;
      indexes[2] = CSR_TONE_PHASE_COUNT;
      indexes[3] = CSR_TICKS_PER_SECOND;
      indexes[4] = CSR_OPEN_SECONDS;
      csr_valid <= 1'b1;
      for (i = 0; i < 5; i++) begin
         csr_index <= indexes[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      plan_cfg = c;
   endtask

   task automatic wait_drained();
      while (!(events_accepted == events_queued && due_outputs.size() == 0))
         @(posedge clock);
   endtask

   function automatic logic [31:0] random_digit_code();
      logic [31:0] c;
      int          i;
      for (i = 0; i < 8; i++) c[4*i +: 4] = 4'($urandom_range(0, 9));
      return c;
   endfunction

   // Mostly well-formed entries, door runs and tones, with some noise in between.
   task automatic fill_phase(input int budget);
      int start;
      int n;
      int tps;
      int i;
      start = events_queued;
      while (events_queued - start < budget) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: begin
               type_code();
               tps = (plan_cfg.ticks_per_second == 0) ? 64 : int'(plan_cfg.ticks_per_second);
               n = tps * int'(plan_cfg.open_seconds);
               if (n > MAX_TICK_RUN) n = $urandom_range(5, 40);
               if ($urandom_range(0, 3) == 0) n = $urandom_range(0, n);
               add_repeated(FUNC_TICK, n);
            end
            6, 7, 8, 9: begin
               if ($urandom_range(0, 1) == 1) add_event(FUNC_KEY, KEY_CLEAR);
               n = $urandom_range(1, CODE_LEN);
               for (i = 0; i < n; i++) add_event(FUNC_KEY, 4'($urandom_range(0, 9)));
               n = $urandom_range(1, 3);
               for (i = 0; i < n; i++) add_event(FUNC_KEY, KEY_CONFIRM);
            end
            10, 11, 12: begin
               add_event(FUNC_KEY, KEY_BELL);
               n = 2 * int'(plan_cfg.tone_phase_count) + 1;
               if (n > 80) n = $urandom_range(10, 40);
               add_repeated(FUNC_TONE, n);
            end
            13, 14: add_repeated(FUNC_TONE, $urandom_range(1, 15));
            15, 16: add_repeated(FUNC_TICK, $urandom_range(1, 20));
            default: begin
               n = $urandom_range(1, 4);
               for (i = 0; i < n; i++)
                  add_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            end
         endcase
      end
   endtask

   initial begin
      kcl_cfg_type c;
      int          p;
      logic [3:0]  k;
      plan_cfg.code_digits = RESET_CODE;
      plan_cfg.wrong_limit = RESET_WRONG_LIMIT;
      plan_cfg.tone_phase_count = RESET_PHASE_COUNT;
      plan_cfg.ticks_per_second = RESET_TICKS;
      plan_cfg.open_seconds = RESET_OPEN;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset settings: ignored words, a good code, a run of bad
      // confirms into the alarm, the bell cutting in on the alarm, and digit extremes.
      add_event(FUNC_NONE, 4'd0);
      for (k = KEY_CONFIRM + 4'd1; k < KEY_BELL; k++) add_event(FUNC_KEY, k);
      add_event(FUNC_TONE, 4'd0);
      add_event(FUNC_TICK, 4'd0);
      type_code();
      add_event(FUNC_KEY, 4'd9);
      add_event(FUNC_KEY, KEY_CONFIRM);
      add_event(FUNC_KEY, KEY_CONFIRM);
      add_event(FUNC_KEY, KEY_CONFIRM);
      add_event(FUNC_TONE, 4'd0);
      add_event(FUNC_KEY, KEY_BELL);
      add_event(FUNC_TONE, 4'd0);
      add_event(FUNC_KEY, KEY_CLEAR);
      add_event(FUNC_KEY, 4'd0);
      wait_drained();

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: c = '{random_digit_code(), 4'd1, 10'd1, 6'd1, 4'd1};
            1: c = '{32'h9999_9999, 4'd15, 10'd1023, 6'd63, 4'd15};
            // All zero limits, and a code that no typed entry can match.
            2: c = '{32'hFFFF_FFFF, 4'd0, 10'd0, 6'd0, 4'd0};
            3: c = '{32'h0000_0000, 4'd2, 10'd3, 6'd2, 4'd2};
            4: c = '{32'($urandom()), 4'($urandom_range(1, 5)), 10'($urandom_range(1, 8)),
                     6'($urandom_range(1, 6)), 4'($urandom_range(1, 4))};
            default: c = '{random_digit_code(), 4'($urandom_range(1, 4)),
                           10'($urandom_range(1, 6)), 6'($urandom_range(1, 4)),
                           4'($urandom_range(1, 3))};
         endcase
         load_registers(c);
         fill_phase(PHASE_WORDS);
         // Hold the result side off for a while so that the block backs up.
         if (p == 4) holds_asked++;
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (due_outputs.size() != 0) begin
         $display("%0t: %0d predicted results never arrived", $time, due_outputs.size());
         error_count += due_outputs.size();
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
